### sv/blid_pkg.sv
// ----------------------------------------------------------------------------
// blid_pkg: shared types and constants for the bounded list
// Sizes, operation and status codes, and the command that steers each cell.
// ----------------------------------------------------------------------------
`default_nettype none

package blid_pkg;

    localparam int DEPTH       = 16;
    localparam int ENTRY_WIDTH = 32;

    localparam int OP_W     = 2;
    localparam int POS_W    = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 5;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADIDX = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } t_cell_op;

    typedef struct packed {
        t_cell_op               cmd;
        logic [IDX_W-1:0]       idx;
        logic [ENTRY_WIDTH-1:0] wdata;
    } t_cell_ctrl;

    typedef struct packed {
        t_status          status;
        logic             read_hit;
        logic [IDX_W-1:0] read_idx;
        logic [CNT_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

### sv/blid_if.sv
// ----------------------------------------------------------------------------
// blid_if: request and response channels of the bounded list
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface blid_req_if
    import blid_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] entry_data;

    modport source (output valid, output op, output position, output entry_data,
                    input ready);
    modport sink   (input valid, input op, input position, input entry_data,
                    output ready);
endinterface

interface blid_rsp_if
    import blid_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_data;
    logic [CNT_W-1:0]    entry_count;

    modport source (output valid, output status, output read_data, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input read_data, input entry_count,
                    output ready);
endinterface

`default_nettype wire

### sv/bounded_list_insert_delete.sv
// ----------------------------------------------------------------------------
// bounded_list_insert_delete: bounded ordered list with insert and delete
// The result of a request is registered and valid in the cycle after its transfer.
// Throughput: one request per cycle while results are taken; the cell chain shifts all entries at once.
// While a result waits to be taken, no request is taken; a new request can
// enter at the same edge at which the waiting result leaves.
// Reset (synchronous, active low) clears the count and the result valid flag
// and sets the capacity to 16; entry words are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_list_insert_delete
    import blid_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata,
    blid_req_if.sink              i_req,
    blid_rsp_if.source            o_rsp
);

    // Request side: take a request whenever the output register is free
    // or its result is leaving in this same cycle.
    logic req_accept;
    logic r_rsp_valid;

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign req_accept  = i_req.valid && i_req.ready;

    t_cell_ctrl cell_ctrl;
    t_result    result;

    blid_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (req_accept),
        .i_op         (i_req.op),
        .i_position   (i_req.position),
        .i_entry_data (i_req.entry_data),
        .o_cell_ctrl  (cell_ctrl),
        .o_result     (result)
    );

    // The chain of cells. Each inner cell sees both neighbors; the two ends see their own word in place
    // of the missing one. The bottom cell never picks it; the top cell takes it on a delete and so keeps its word.
    logic [ENTRY_WIDTH-1:0] cell_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ENTRY_WIDTH-1:0] lower;
        logic [ENTRY_WIDTH-1:0] upper;

        if (g == 0) begin : g_first
            assign lower = cell_data[g];
        end else begin : g_mid_lo
            assign lower = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign upper = cell_data[g];
        end else begin : g_mid_hi
            assign upper = cell_data[g+1];
        end

        blid_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_cell_idx (IDX_W'(g)),
            .i_lower    (lower),
            .i_upper    (upper),
            .o_data     (cell_data[g])
        );
    end

    // A read uses the words as they stand before this request; a read never
    // changes the list, so no shift is in flight at the same time.
    logic [DATA_W-1:0] read_word;

    always_comb begin
        read_word = '0;
        if (result.read_hit) begin
            read_word = DATA_W'(cell_data[result.read_idx]);
        end
    end

    // Output register: one result per accepted request.
    t_status           r_status;
    logic [DATA_W-1:0] r_read_data;
    logic [CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (req_accept) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_status    <= result.status;
            r_read_data <= read_word;
            r_count     <= result.count;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.read_data   = r_read_data;
    assign o_rsp.entry_count = r_count;

endmodule

`default_nettype wire

### sv/blid_cell.sv
// ----------------------------------------------------------------------------
// blid_cell: one entry slot of the list
// Holds one entry word; loads new data, takes its lower neighbor on an
// insert above the position, or its upper neighbor on a delete at or above it.
// ----------------------------------------------------------------------------
`default_nettype none

module blid_cell
    import blid_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire t_cell_ctrl             i_ctrl,
    input  wire logic [IDX_W-1:0]       i_cell_idx,
    input  wire logic [ENTRY_WIDTH-1:0] i_lower,
    input  wire logic [ENTRY_WIDTH-1:0] i_upper,
    output logic      [ENTRY_WIDTH-1:0] o_data
);

    logic [ENTRY_WIDTH-1:0] r_data;
    logic [ENTRY_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.cmd)
            CELL_INSERT: begin
                if (i_cell_idx == i_ctrl.idx) begin
                    n_data = i_ctrl.wdata;
                end else if (i_cell_idx > i_ctrl.idx) begin
                    n_data = i_lower;
                end
            end
            CELL_DELETE: begin
                if (i_cell_idx >= i_ctrl.idx) begin
                    n_data = i_upper;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### sv/blid_ctrl.sv
// ----------------------------------------------------------------------------
// blid_ctrl: request decode, count and capacity for the bounded list
// Checks full and position range, steers the cell chain, tracks the count.
// ----------------------------------------------------------------------------
`default_nettype none

module blid_ctrl
    import blid_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CAP_W-1:0]  i_cfg_wdata,
    input  wire logic              i_accept,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [DATA_W-1:0] i_entry_data,
    output t_cell_ctrl             o_cell_ctrl,
    output t_result                o_result
);

    logic [CAP_W-1:0] r_capacity;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic [CMP_W-1:0] pos_cmp;
    logic [CMP_W-1:0] cnt_cmp;
    logic             full;
    logic             full_cap;

    // Effective capacity saturates at the depth; compare in the wider width.
    always_comb begin
        full_cap = (32'(r_capacity) > 32'(DEPTH));
        full     = full_cap ? (32'(r_count) >= 32'(DEPTH))
                            : (32'(r_count) >= 32'(r_capacity));
        pos_cmp  = CMP_W'(i_position);
        cnt_cmp  = CMP_W'(r_count);
    end

    always_comb begin
        o_cell_ctrl.cmd   = CELL_HOLD;
        o_cell_ctrl.idx   = IDX_W'(pos_cmp);
        o_cell_ctrl.wdata = ENTRY_WIDTH'(i_entry_data);
        o_result.status   = ST_OK;
        o_result.read_hit = 1'b0;
        o_result.read_idx = IDX_W'(pos_cmp);
        n_count           = r_count;
        case (t_op'(i_op))
            OP_APPEND: begin
                if (full) begin
                    o_result.status = ST_FULL;
                end else begin
                    // An append is an insert at the tail.
                    o_cell_ctrl.cmd = CELL_INSERT;
                    o_cell_ctrl.idx = IDX_W'(r_count);
                    n_count         = r_count + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (full) begin
                    o_result.status = ST_FULL;
                end else if (pos_cmp > cnt_cmp) begin
                    o_result.status = ST_BADIDX;
                end else begin
                    o_cell_ctrl.cmd = CELL_INSERT;
                    n_count         = r_count + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (pos_cmp >= cnt_cmp) begin
                    o_result.status = ST_BADIDX;
                end else begin
                    o_cell_ctrl.cmd = CELL_DELETE;
                    n_count         = r_count - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (pos_cmp >= cnt_cmp) begin
                    o_result.status = ST_BADIDX;
                end else begin
                    o_result.read_hit = 1'b1;
                end
            end
            default: o_result.status = ST_OK;
        endcase
        if (!i_accept) begin
            o_cell_ctrl.cmd = CELL_HOLD;
            n_count         = r_count;
        end
        o_result.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(16);
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire
